// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL; fqr_ctrl.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fqr_pkg.sv =====
`timescale 1ns / 1ps

package fqr_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ID_W    = 32;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_SERVE  = 2'd1,
      OP_REMOVE = 2'd2,
      OP_LIST   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic               valid;
      status_type         status;
      logic [ID_W-1:0]    id;
      logic [COUNT_W-1:0] count;
      logic               last;
   } res_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [ID_W-1:0]  wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } ram_cmd_type;

   // Step one slot round the ring.
   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] p);
      logic [IDX_W-1:0] r;
      if (p == IDX_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + IDX_W'(1);
      end
      return r;
   endfunction

   // Slot that lies c places behind p round the ring (c at most DEPTH).
   function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] p,
                                                input logic [CNT_W-1:0] c);
      logic [CNT_W:0] s;
      s = (CNT_W + 1)'(p) + (CNT_W + 1)'(c);
      if (s >= (CNT_W + 1)'(DEPTH)) begin
         s = s - (CNT_W + 1)'(DEPTH);
      end
      return IDX_W'(s);
   endfunction

endpackage

// ===== sv/fqr_slot_ram.sv =====
`timescale 1ns / 1ps

module fqr_slot_ram #(
   parameter int DATA_W  = 32,
   parameter int ENTRIES = 16,
   parameter int ADDR_W  = $clog2(ENTRIES)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [ENTRIES];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fqr_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fqr_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_op,
   input  logic [fqr_pkg::ID_W-1:0]       req_entry_id,
   input  logic                           out_free,
   output fqr_pkg::res_type               res,
   output fqr_pkg::ram_cmd_type           ram_cmd,
   input  logic [fqr_pkg::ID_W-1:0]       rd_data
);

   import fqr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SERVE,
      S_SCAN,
      S_SHIFT,
      S_LIST,
      S_EMIT
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] occ_ff;
   logic [IDX_W-1:0] head_ff;
   logic [IDX_W-1:0] ptr_ff;
   logic [CNT_W-1:0] k_ff;
   logic [ID_W-1:0]  id_ff;
   status_type       status_ff;
   logic [ID_W-1:0]  out_id_ff;

   logic             accept;
   logic             is_last;
   logic             id_hit;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_last   = ((k_ff + CNT_W'(1)) == occ_ff);
   // The one shared compare, used by every step of the search.
   assign id_hit    = (rd_data == id_ff);

   always_comb begin
      ram_cmd         = '0;
      ram_cmd.wr_addr = ptr_ff;
      ram_cmd.rd_addr = ptr_ff;
      ram_cmd.wr_data = rd_data;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_ADD) begin
                  ram_cmd.wr_en   = (occ_ff != CNT_W'(DEPTH));
                  ram_cmd.wr_addr = idx_add(head_ff, occ_ff);
                  ram_cmd.wr_data = req_entry_id;
               end else begin
                  ram_cmd.rd_en   = 1'b1;
                  ram_cmd.rd_addr = head_ff;
               end
            end
         end
         S_SCAN: begin
            ram_cmd.rd_en   = 1'b1;
            ram_cmd.rd_addr = idx_next(ptr_ff);
         end
         S_SHIFT: begin
            // Move the entry behind ptr forward, fetch the one after it.
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.rd_en   = 1'b1;
            ram_cmd.rd_addr = idx_next(idx_next(ptr_ff));
         end
         S_LIST: begin
            ram_cmd.rd_en   = out_free;
            ram_cmd.rd_addr = idx_next(ptr_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      res.valid  = (state_ff == S_EMIT) || (state_ff == S_LIST);
      res.count  = COUNT_W'(occ_ff);
      if (state_ff == S_LIST) begin
         res.status = ST_OK;
         res.id     = rd_data;
         res.last   = is_last;
      end else begin
         res.status = status_ff;
         res.id     = out_id_ff;
         res.last   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
         head_ff  <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  id_ff     <= req_entry_id;
                  out_id_ff <= '0;
                  ptr_ff    <= head_ff;
                  k_ff      <= '0;
                  status_ff <= ST_OK;
                  case (req_op)
                     OP_ADD: begin
                        if (occ_ff == CNT_W'(DEPTH)) begin
                           status_ff <= ST_FULL;
                        end else begin
                           occ_ff <= occ_ff + CNT_W'(1);
                        end
                        state_ff <= S_EMIT;
                     end
                     OP_SERVE: begin
                        if (occ_ff == '0) begin
                           status_ff <= ST_EMPTY;
                           state_ff  <= S_EMIT;
                        end else begin
                           state_ff <= S_SERVE;
                        end
                     end
                     OP_REMOVE: begin
                        if (occ_ff == '0) begin
                           status_ff <= ST_EMPTY;
                           state_ff  <= S_EMIT;
                        end else begin
                           state_ff <= S_SCAN;
                        end
                     end
                     default: begin
                        if (occ_ff == '0) begin
                           status_ff <= ST_EMPTY;
                           state_ff  <= S_EMIT;
                        end else begin
                           state_ff <= S_LIST;
                        end
                     end
                  endcase
               end
            end
            S_SERVE: begin
               out_id_ff <= rd_data;
               head_ff   <= idx_next(head_ff);
               occ_ff    <= occ_ff - CNT_W'(1);
               state_ff  <= S_EMIT;
            end
            S_SCAN: begin
               if (id_hit) begin
                  if (is_last) begin
                     occ_ff   <= occ_ff - CNT_W'(1);
                     state_ff <= S_EMIT;
                  end else begin
                     state_ff <= S_SHIFT;
                  end
               end else if (is_last) begin
                  status_ff <= ST_NOT_FOUND;
                  state_ff  <= S_EMIT;
               end else begin
                  ptr_ff <= idx_next(ptr_ff);
                  k_ff   <= k_ff + CNT_W'(1);
               end
            end
            S_SHIFT: begin
               // Stop once the tail entry has moved forward.
               if ((k_ff + CNT_W'(2)) == occ_ff) begin
                  occ_ff   <= occ_ff - CNT_W'(1);
                  state_ff <= S_EMIT;
               end else begin
                  ptr_ff <= idx_next(ptr_ff);
                  k_ff   <= k_ff + CNT_W'(1);
               end
            end
            S_LIST: begin
               if (out_free) begin
                  if (is_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     ptr_ff <= idx_next(ptr_ff);
                     k_ff   <= k_ff + CNT_W'(1);
                  end
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `ASSERT_ALWAYS(a_occ_bound, clock, reset, occ_ff <= CNT_W'(DEPTH), "occupancy beyond depth")
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_ready, "ready while item in work")
   `ASSERT_NEXT(a_add_grows, clock, reset, accept && (req_op == OP_ADD) && (occ_ff != CNT_W'(DEPTH)), occ_ff == $past(occ_ff) + CNT_W'(1), "add did not grow the queue")

endmodule

// ===== sv/fifo_queue_with_remove_by_id_core.sv =====
`timescale 1ns / 1ps
// Ordered queue of identifiers with add, serve, remove-by-identifier and list.
// Request channel (req_*): valid/ready; one item carries an operation and an
// identifier. Response channel (rsp_*): valid/ready; every response carries
// status, identifier, the count after the operation and a last mark.
// Entries sit in a ring in a single-port-read slot RAM; one sequencer with one
// identifier compare walks them one slot per cycle, a list only while the
// response register is free. Remove searches up to the match, then the later
// entries close the gap one slot a cycle, one pass in all. An item holds the
// sequencer until its response is loaded into the output register, so a new
// item is not taken before the last one is through.
// req_ready is high only while the sequencer is idle; an item is taken while
// the previous response still waits in the output register.
// A stalled receiver holds the response register; the sequencer then waits, so
// a list resumes where it stopped. Reset empties the queue at once; slot
// contents are not cleared and are never read before being written.
module fifo_queue_with_remove_by_id_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_op,
   input  logic signed [fqr_pkg::ID_W-1:0]   req_entry_id,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic signed [fqr_pkg::ID_W-1:0]   rsp_out_id,
   output logic [fqr_pkg::COUNT_W-1:0]       rsp_count,
   output logic                              rsp_last
);

   import fqr_pkg::*;

   res_type              res;
   ram_cmd_type          ram_cmd;
   logic [ID_W-1:0]      rd_data;
   logic                 out_free;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [ID_W-1:0]      rsp_out_id_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   fqr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_entry_id (req_entry_id),
      .out_free     (out_free),
      .res          (res),
      .ram_cmd      (ram_cmd),
      .rd_data      (rd_data)
   );

   fqr_slot_ram #(
      .DATA_W  (ID_W),
      .ENTRIES (DEPTH),
      .ADDR_W  (IDX_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load the payload only when the register is free or being emptied.
   always_ff @(posedge clock) begin
      if (res.valid && out_free) begin
         rsp_status_ff <= res.status;
         rsp_out_id_ff <= res.id;
         rsp_count_ff  <= res.count;
         rsp_last_ff   <= res.last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_out_id = $signed(rsp_out_id_ff);
   assign rsp_count  = rsp_count_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
